// ===== design/lfc_pkg.sv =====
// Shared types and constants for the LRU frame cache.
// Used by lfc_csr and lru_frame_cache; no dependencies.
package lfc_pkg;

   localparam int CAPACITY     = 64;
   localparam int PAYLOAD_BITS = 64;
   localparam int IDX_W        = $clog2(CAPACITY);
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int KEY_W        = 16;
   localparam int STAMP_W      = 16;
   localparam int DATA_W       = 64;
   localparam int ENTRIES_W    = 7;
   localparam int STATUS_W     = 2;
   localparam int ADDR_W       = 3;
   localparam int REG_W        = 32;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OFF  = 2'd2;

   localparam logic REG_ENTRIES = 1'b0;
   localparam logic REG_ENABLE  = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0] active;
      logic             enabled;
      logic             clear;
   } cfg_type;

endpackage

// ===== design/lru_frame_cache.sv =====
// Fully associative frame cache with timestamp LRU replacement, top level.
// Depends on lfc_pkg and lfc_csr.
//
// Usage:
//   req_* carries one item: tuser = operation (0 get, 1 put); tdata holds
//   frame_number and frame_data. rsp_* returns one item per request:
//   tuser = status (0 ok/hit, 1 get miss, 2 disabled); tdata holds read_data
//   and slot. csr_* sets entries_in_use (0x0) and cache_enabled (0x4);
//   enabling a disabled cache empties it.
// Timing:
//   One item at a time. A shared compare unit walks the key store one entry
//   per cycle, stopping early on a hit; a put that misses with every active
//   slot filled walks the stamp store again, a get hit adds a payload read,
//   and each item ends with accept and commit; a disabled cache skips the
//   walks and goes straight to commit. Storage reads are registered.
// Reset and stall:
//   Reset empties the cache, disables it and sets 64 entries. The result
//   sits in an output register; while rsp_tready is low the commit of the
//   next item waits and req_tready stays low until the block is idle again.
module lru_frame_cache (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [79:0]                req_tdata,  // frame_number[15:0], frame_data[79:16]
   input  logic [0:0]                 req_tuser,  // operation[0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [71:0]                rsp_tdata,  // read_data[63:0], slot[69:64], zero pad
   output logic [1:0]                 rsp_tuser,  // status[1:0]
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [lfc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [lfc_pkg::REG_W-1:0]  csr_pwdata,
   output logic [lfc_pkg::REG_W-1:0]  csr_prdata,
   output logic                       csr_pready
);
   import lfc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRCH = 3'd1;
   localparam logic [2:0] S_LRU  = 3'd2;
   localparam logic [2:0] S_RDP  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   cfg_type cfg;

   lfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // storage
   logic [KEY_W-1:0]        key_ram   [CAPACITY];
   logic [STAMP_W-1:0]      stamp_ram [CAPACITY];
   logic [PAYLOAD_BITS-1:0] pay_ram   [CAPACITY];
   logic [KEY_W-1:0]        rd_key_ff;
   logic [STAMP_W-1:0]      rd_stamp_ff;
   logic [PAYLOAD_BITS-1:0] rd_pay_ff;

   logic [2:0]              state_ff, state_in;
   logic                    op_ff, op_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] data_ff, data_in;
   logic                    off_ff, off_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        pidx_ff, pidx_in;
   logic                    hit_ff, hit_in;
   logic [IDX_W-1:0]        tgt_ff, tgt_in;
   logic [STAMP_W-1:0]      best_ff, best_in;
   logic                    take_ff, take_in;
   logic [CAPACITY-1:0]     valid_ff, valid_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [STAMP_W-1:0]      use_ff, use_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]        rsp_slot_ff, rsp_slot_in;

   logic                    req_fire;
   logic                    out_free;
   logic                    commit;
   logic                    commit_ok;
   logic [IDX_W-1:0]        rd_addr;
   logic                    issue;
   logic                    scan_end;
   logic [STAMP_W-1:0]      stamp_eff;
   logic [15:0]             cmp_a, cmp_b;
   logic                    cmp_eq, cmp_lt;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == S_DONE) && out_free;
   assign commit_ok  = commit && !off_ff && ((op_ff == OP_PUT) || hit_ff);

   assign rd_addr   = (state_ff == S_RDP) ? tgt_ff : idx_ff[IDX_W-1:0];
   assign issue     = (idx_ff < cfg.active);
   assign scan_end  = !issue && !pend_ff;
   assign stamp_eff = valid_ff[pidx_ff] ? rd_stamp_ff : '0;

   // shared compare unit: key match in search, stamp order in LRU walk
   assign cmp_a  = (state_ff == S_LRU) ? stamp_eff : rd_key_ff;
   assign cmp_b  = (state_ff == S_LRU) ? best_ff : key_ff;
   assign cmp_eq = (cmp_a == cmp_b);
   assign cmp_lt = (cmp_a < cmp_b);

   always_ff @(posedge clock) begin
      rd_key_ff   <= key_ram[rd_addr];
      rd_stamp_ff <= stamp_ram[rd_addr];
      if (commit_ok) begin
         stamp_ram[tgt_ff] <= use_ff + STAMP_W'(1);
         if (op_ff == OP_PUT) begin
            key_ram[tgt_ff] <= key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RDP) begin
         rd_pay_ff <= pay_ram[rd_addr];
      end
      if (commit_ok && (op_ff == OP_PUT)) begin
         pay_ram[tgt_ff] <= data_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      data_in       = data_ff;
      off_in        = off_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pidx_in       = pidx_ff;
      hit_in        = hit_ff;
      tgt_in        = tgt_ff;
      best_in       = best_ff;
      take_in       = take_ff;
      valid_in      = valid_ff;
      fill_in       = fill_ff;
      use_in        = use_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_slot_in   = rsp_slot_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if ((state_ff == S_SRCH) || (state_ff == S_LRU)) begin
         if (issue) begin
            idx_in  = idx_ff + CNT_W'(1);
            pend_in = 1'b1;
            pidx_in = idx_ff[IDX_W-1:0];
         end else begin
            pend_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_tuser[0];
               key_in  = req_tdata[KEY_W-1:0];
               data_in = req_tdata[KEY_W +: PAYLOAD_BITS];
               off_in  = !cfg.enabled;
               idx_in  = '0;
               pend_in = 1'b0;
               hit_in  = 1'b0;
               take_in = 1'b0;
               tgt_in  = '0;
               state_in = cfg.enabled ? S_SRCH : S_DONE;
            end
         end
         S_SRCH: begin
            if (pend_ff && valid_ff[pidx_ff] && cmp_eq) begin
               hit_in   = 1'b1;
               tgt_in   = pidx_ff;
               state_in = (op_ff == OP_PUT) ? S_DONE : S_RDP;
            end else if (scan_end) begin
               if (op_ff == OP_GET) begin
                  state_in = S_DONE;
               end else if (fill_ff < cfg.active) begin
                  tgt_in   = fill_ff[IDX_W-1:0];
                  take_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = S_LRU;
               end
            end
         end
         S_LRU: begin
            if (pend_ff && ((pidx_ff == '0) || cmp_lt)) begin
               best_in = cmp_a;
               tgt_in  = pidx_ff;
            end
            if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_RDP: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (off_ff) begin
                  rsp_status_in = STATUS_OFF;
               end else if ((op_ff == OP_GET) && !hit_ff) begin
                  rsp_status_in = STATUS_MISS;
               end else begin
                  rsp_status_in = STATUS_OK;
               end
               rsp_data_in = (!off_ff && (op_ff == OP_GET) && hit_ff) ?
                             DATA_W'(rd_pay_ff) : '0;
               rsp_slot_in = commit_ok ? tgt_ff : '0;
               if (commit_ok) begin
                  valid_in[tgt_ff] = 1'b1;
                  use_in           = use_ff + STAMP_W'(1);
                  if (take_ff) begin
                     fill_in = fill_ff + CNT_W'(1);
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg.clear) begin
         valid_in = '0;
         fill_in  = '0;
         use_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         fill_ff      <= '0;
         use_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         use_ff       <= use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      data_ff       <= data_in;
      off_ff        <= off_in;
      idx_ff        <= idx_in;
      pidx_ff       <= pidx_in;
      hit_ff        <= hit_in;
      tgt_ff        <= tgt_in;
      best_ff       <= best_in;
      take_ff       <= take_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(72-DATA_W-IDX_W){1'b0}}, rsp_slot_ff, rsp_data_ff};

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      (commit_ok && !cfg.clear) |=> valid_ff[$past(tgt_ff)])
      else $error("committed entry not marked valid");

   a_use_step: assert property (@(posedge clock) disable iff (reset)
      (commit_ok && !cfg.clear) |=> (use_ff == $past(use_ff) + STAMP_W'(1)))
      else $error("use clock did not advance on commit");

   a_off_result: assert property (@(posedge clock) disable iff (reset)
      (commit && off_ff) |=> (rsp_tvalid && rsp_tuser == STATUS_OFF &&
                              rsp_tdata == '0))
      else $error("disabled item returned data");
`endif

endmodule

// ===== design/lfc_csr.sv =====
// Configuration registers of the LRU frame cache behind an APB-style port.
// Depends on lfc_pkg; produces the active entry count, enable and clear pulse.
module lfc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [lfc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [lfc_pkg::REG_W-1:0]  csr_pwdata,
   output logic [lfc_pkg::REG_W-1:0]  csr_prdata,
   output logic                       csr_pready,
   output lfc_pkg::cfg_type           cfg
);
   import lfc_pkg::*;

   logic [ENTRIES_W-1:0] entries_ff, entries_in;
   logic                 enabled_ff, enabled_in;
   logic                 wr;
   logic                 sel_enable;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign sel_enable = (csr_paddr[2] == REG_ENABLE);

   always_comb begin
      entries_in = entries_ff;
      enabled_in = enabled_ff;
      if (wr && !sel_enable) begin
         entries_in = csr_pwdata[ENTRIES_W-1:0];
      end
      if (wr && sel_enable) begin
         enabled_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_W'(CAPACITY);
         enabled_ff <= 1'b0;
      end else begin
         entries_ff <= entries_in;
         enabled_ff <= enabled_in;
      end
   end

   always_comb begin
      if (sel_enable) begin
         csr_prdata = {{(REG_W-1){1'b0}}, enabled_ff};
      end else begin
         csr_prdata = {{(REG_W-ENTRIES_W){1'b0}}, entries_ff};
      end
   end

   // zero counts as one entry, large values saturate at capacity
   always_comb begin
      cfg.enabled = enabled_ff;
      cfg.clear   = wr && sel_enable && csr_pwdata[0] && !enabled_ff;
      if (entries_ff == '0) begin
         cfg.active = CNT_W'(1);
      end else if (entries_ff > ENTRIES_W'(CAPACITY)) begin
         cfg.active = CNT_W'(CAPACITY);
      end else begin
         cfg.active = CNT_W'(entries_ff);
      end
   end

endmodule
